### sv/binary_frame_class_id_matcher_top_macros.svh
// Assertion macros shared by the frame matcher RTL.
`ifndef BINARY_FRAME_CLASS_ID_MATCHER_TOP_MACROS_SVH
`define BINARY_FRAME_CLASS_ID_MATCHER_TOP_MACROS_SVH

// Clocked check, held off while reset is high.
`define BFCM_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked check that also holds during reset.
`define BFCM_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

### sv/bfcm_pkg.sv
// Shared types and constants for the frame class/id matcher.
package bfcm_pkg;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 16;

  // register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_CLASS   = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_ID      = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_LIMIT   = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_WINDOW  = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_GAP     = 3'd4;

  // register reset values
  localparam logic [7:0]  RST_CLASS  = 8'd5;
  localparam logic [7:0]  RST_ID     = 8'd1;
  localparam logic [15:0] RST_LIMIT  = 16'd256;
  localparam logic [15:0] RST_WINDOW = 16'd800;
  localparam logic [15:0] RST_GAP    = 16'd1000;

  // frame sync bytes
  localparam logic [7:0] SYNC_A = 8'hB5;
  localparam logic [7:0] SYNC_B = 8'h62;

  // input function codes
  localparam logic [1:0] FUNC_START = 2'd0;
  localparam logic [1:0] FUNC_BYTE  = 2'd1;
  localparam logic [1:0] FUNC_TICK  = 2'd2;

  // result kinds
  localparam logic [1:0] KIND_PAYLOAD = 2'd0;
  localparam logic [1:0] KIND_TIMEOUT = 2'd1;
  localparam logic [1:0] KIND_EMPTY   = 2'd2;

  typedef struct packed {
    logic [1:0] func;
    logic [7:0] rx_byte;
  } in_t;

  typedef struct packed {
    logic [1:0]  kind;
    logic [7:0]  payload_byte;
    logic        last;
    logic [15:0] frame_length;
  } out_t;

  typedef struct packed {
    logic [7:0]  match_class;
    logic [7:0]  match_id;
    logic [15:0] length_limit;
    logic [15:0] window_ticks;
    logic [15:0] gap_ticks;
  } cfg_t;

endpackage

### sv/bfcm_cfg.sv
// Configuration register file for the frame matcher.
module bfcm_cfg (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_we,
  input  logic [bfcm_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [bfcm_pkg::CFG_DATA_W-1:0]  cfg_data,
  output bfcm_pkg::cfg_t                   cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.match_class  <= bfcm_pkg::RST_CLASS;
      cfg.match_id     <= bfcm_pkg::RST_ID;
      cfg.length_limit <= bfcm_pkg::RST_LIMIT;
      cfg.window_ticks <= bfcm_pkg::RST_WINDOW;
      cfg.gap_ticks    <= bfcm_pkg::RST_GAP;
    end else if (cfg_we) begin
      unique case (cfg_index)
        bfcm_pkg::REG_CLASS:  cfg.match_class  <= cfg_data[7:0];
        bfcm_pkg::REG_ID:     cfg.match_id     <= cfg_data[7:0];
        bfcm_pkg::REG_LIMIT:  cfg.length_limit <= cfg_data;
        bfcm_pkg::REG_WINDOW: cfg.window_ticks <= cfg_data;
        bfcm_pkg::REG_GAP:    cfg.gap_ticks    <= cfg_data;
        default: ;
      endcase
    end
  end

endmodule

### sv/bfcm_core.sv
// Header hunt, length capture and payload streaming state machine.
`include "binary_frame_class_id_matcher_top_macros.svh"

module bfcm_core (
  input  logic           clk,
  input  logic           rst,
  input  logic           accept,
  input  bfcm_pkg::in_t  in_data,
  input  bfcm_pkg::cfg_t cfg,
  output logic           res_valid,
  output bfcm_pkg::out_t res
);

  localparam logic [2:0] PH_IDLE    = 3'd0;
  localparam logic [2:0] PH_SYNC_A  = 3'd1;
  localparam logic [2:0] PH_SYNC_B  = 3'd2;
  localparam logic [2:0] PH_CLASS   = 3'd3;
  localparam logic [2:0] PH_ID      = 3'd4;
  localparam logic [2:0] PH_LEN_LO  = 3'd5;
  localparam logic [2:0] PH_LEN_HI  = 3'd6;
  localparam logic [2:0] PH_PAYLOAD = 3'd7;

  logic [2:0]  phase, phase_next;
  logic [15:0] payload_length, payload_length_next;
  logic [15:0] bytes_seen, bytes_seen_next;
  logic [15:0] window_count, window_count_next;
  logic [15:0] gap_count, gap_count_next;

  logic [15:0] win_inc, gap_inc, seen_inc, len_full;
  logic [7:0]  b;

  assign b        = in_data.rx_byte;
  assign win_inc  = window_count + 16'd1;
  assign gap_inc  = gap_count + 16'd1;
  assign seen_inc = bytes_seen + 16'd1;
  assign len_full = {b, payload_length[7:0]};

  always_comb begin
    phase_next          = phase;
    payload_length_next = payload_length;
    bytes_seen_next     = bytes_seen;
    window_count_next   = window_count;
    gap_count_next      = gap_count;
    res_valid           = 1'b0;
    res                 = '0;
    if (accept) begin
      if (in_data.func == bfcm_pkg::FUNC_START) begin
        phase_next          = PH_SYNC_A;
        payload_length_next = '0;
        bytes_seen_next     = '0;
        window_count_next   = '0;
        gap_count_next      = '0;
      end else if (phase != PH_IDLE && in_data.func == bfcm_pkg::FUNC_TICK) begin
        if (phase == PH_PAYLOAD) begin
          // idle gap inside a payload; window is left alone
          gap_count_next = gap_inc;
          if (gap_inc >= cfg.gap_ticks) begin
            phase_next      = PH_SYNC_A;
            gap_count_next  = '0;
            bytes_seen_next = '0;
          end
        end else begin
          window_count_next = win_inc;
          if (win_inc >= cfg.window_ticks) begin
            phase_next   = PH_IDLE;
            res_valid    = 1'b1;
            res.kind     = bfcm_pkg::KIND_TIMEOUT;
            res.last     = 1'b1;
          end
        end
      end else if (phase != PH_IDLE && in_data.func == bfcm_pkg::FUNC_BYTE) begin
        unique case (phase)
          PH_SYNC_A: if (b == bfcm_pkg::SYNC_A) phase_next = PH_SYNC_B;
          PH_SYNC_B: phase_next = (b == bfcm_pkg::SYNC_B) ? PH_CLASS : PH_SYNC_A;
          PH_CLASS:  phase_next = (b == cfg.match_class) ? PH_ID : PH_SYNC_A;
          PH_ID:     phase_next = (b == cfg.match_id) ? PH_LEN_LO : PH_SYNC_A;
          PH_LEN_LO: begin
            payload_length_next = {8'd0, b};
            phase_next          = PH_LEN_HI;
          end
          PH_LEN_HI: begin
            payload_length_next = len_full;
            if (len_full >= cfg.length_limit) begin
              phase_next = PH_SYNC_A;
            end else if (len_full == 16'd0) begin
              phase_next = PH_IDLE;
              res_valid  = 1'b1;
              res.kind   = bfcm_pkg::KIND_EMPTY;
              res.last   = 1'b1;
            end else begin
              bytes_seen_next = '0;
              gap_count_next  = '0;
              phase_next      = PH_PAYLOAD;
            end
          end
          PH_PAYLOAD: begin
            bytes_seen_next  = seen_inc;
            gap_count_next   = '0;
            res_valid        = 1'b1;
            res.kind         = bfcm_pkg::KIND_PAYLOAD;
            res.payload_byte = b;
            res.last         = (seen_inc >= payload_length);
            res.frame_length = payload_length;
            if (seen_inc >= payload_length) phase_next = PH_IDLE;
          end
          default: phase_next = PH_IDLE;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_IDLE;
      payload_length <= '0;
      bytes_seen     <= '0;
      window_count   <= '0;
      gap_count      <= '0;
    end else begin
      phase          <= phase_next;
      payload_length <= payload_length_next;
      bytes_seen     <= bytes_seen_next;
      window_count   <= window_count_next;
      gap_count      <= gap_count_next;
    end
  end

  `BFCM_ASSERT(a_res_needs_search, clk, rst, res_valid |-> phase != PH_IDLE, "result while idle")
  `BFCM_ASSERT(a_terminal_goes_idle, clk, rst, (res_valid && res.last) |=> phase == PH_IDLE, "no idle after terminal result")
  `BFCM_ASSERT(a_payload_count, clk, rst, phase == PH_PAYLOAD |-> (bytes_seen < payload_length), "payload count past length")

endmodule

### sv/bfcm_out.sv
// Result register between the matcher and the output channel.
`include "binary_frame_class_id_matcher_top_macros.svh"

module bfcm_out (
  input  logic           clk,
  input  logic           rst,
  input  logic           load,
  input  bfcm_pkg::out_t res,
  output logic           take,
  output logic           out_valid,
  input  logic           out_ready,
  output bfcm_pkg::out_t out_data
);

  // free when empty or when the held beat leaves this cycle
  assign take = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (take) begin
      out_valid <= load;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_data <= res;
    end
  end

  `BFCM_ASSERT(a_no_overwrite, clk, rst, (out_valid && !out_ready) |-> !load, "result overwrote a held beat")
  `BFCM_ASSERT_ALWAYS(a_reset_empty, clk, rst |=> !out_valid, "output valid after reset")

endmodule

### sv/binary_frame_class_id_matcher_top.sv
// Top level of the frame class/id matcher.
//
//  channel | dir | handshake             | beat
//  in      | in  | in_valid / in_ready   | bfcm_pkg::in_t  (func, rx_byte)
//  out     | out | out_valid / out_ready | bfcm_pkg::out_t (kind, payload_byte, last, frame_length)
//  cfg     | in  | cfg_we                | cfg_index, cfg_data (write only)
//
// One input beat per cycle while in_ready is high; its result (if any) shows on out in the cycle after acceptance.
// The single result register sits between core and out; in_ready drops only while it holds a stalled beat.
// Synchronous reset: search idle, counters cleared, registers back to defaults.
// Configuration writes take effect on the next cycle.

module binary_frame_class_id_matcher_top (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  bfcm_pkg::in_t                    in_data,
  output logic                             out_valid,
  input  logic                             out_ready,
  output bfcm_pkg::out_t                   out_data,
  input  logic                             cfg_we,
  input  logic [bfcm_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [bfcm_pkg::CFG_DATA_W-1:0]  cfg_data
);

  bfcm_pkg::cfg_t cfg;
  bfcm_pkg::out_t res;
  logic           res_valid;
  logic           accept;
  logic           take;

  assign in_ready = take;
  assign accept   = in_valid && take;

  bfcm_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  bfcm_core u_core (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .in_data   (in_data),
    .cfg       (cfg),
    .res_valid (res_valid),
    .res       (res)
  );

  bfcm_out u_out (
    .clk       (clk),
    .rst       (rst),
    .load      (res_valid),
    .res       (res),
    .take      (take),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

### test/bfcm_frame_checker.sv
// Frame matcher checker: tracks header hunting state and scores each result beat.
`timescale 1ns / 1ps

module bfcm_frame_checker (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  input  logic                             in_ready,
  input  bfcm_pkg::in_t                    in_data,
  input  logic                             out_valid,
  input  logic                             out_ready,
  input  bfcm_pkg::out_t                   out_data,
  input  logic                             cfg_we,
  input  logic [bfcm_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [bfcm_pkg::CFG_DATA_W-1:0]  cfg_data,
  output int                               fail_count,
  output int                               results_due,
  output int                               results_seen
);
  import bfcm_pkg::*;

  typedef enum logic [2:0] {
    HUNT_IDLE,
    HUNT_SYNC_A,
    HUNT_SYNC_B,
    HUNT_CLASS,
    HUNT_ID,
    HUNT_LEN_LO,
    HUNT_LEN_HI,
    HUNT_PAYLOAD
  } hunt_e;

  hunt_e       hunt;
  logic [15:0] frame_len;
  logic [15:0] bytes_in;
  logic [15:0] window_used;
  logic [15:0] gap_used;
  cfg_t        regs;
  out_t        frame_results_q[$];

  // Advances the header matcher by one input beat; returns 1 when a result beat follows.
  function automatic bit match_beat(input in_t beat, output out_t res);
    res = '0;
    case (beat.func)
      FUNC_START: begin
        hunt        = HUNT_SYNC_A;
        frame_len   = '0;
        bytes_in    = '0;
        window_used = '0;
        gap_used    = '0;
        return 1'b0;
      end
      FUNC_TICK: begin
        if (hunt == HUNT_IDLE) return 1'b0;
        if (hunt == HUNT_PAYLOAD) begin
          gap_used = gap_used + 16'd1;
          if (gap_used >= regs.gap_ticks) begin
            // frame abandoned, window keeps its count
            hunt     = HUNT_SYNC_A;
            gap_used = '0;
            bytes_in = '0;
          end
          return 1'b0;
        end
        window_used = window_used + 16'd1;
        if (window_used >= regs.window_ticks) begin
          hunt     = HUNT_IDLE;
          res.kind = KIND_TIMEOUT;
          res.last = 1'b1;
          return 1'b1;
        end
        return 1'b0;
      end
      FUNC_BYTE: begin
        case (hunt)
          HUNT_SYNC_A: if (beat.rx_byte == SYNC_A) hunt = HUNT_SYNC_B;
          HUNT_SYNC_B: begin
            if (beat.rx_byte == SYNC_B) hunt = HUNT_CLASS;
            else hunt = HUNT_SYNC_A;
          end
          HUNT_CLASS: begin
            if (beat.rx_byte == regs.match_class) hunt = HUNT_ID;
            else hunt = HUNT_SYNC_A;
          end
          HUNT_ID: begin
            if (beat.rx_byte == regs.match_id) hunt = HUNT_LEN_LO;
            else hunt = HUNT_SYNC_A;
          end
          HUNT_LEN_LO: begin
            frame_len = {8'h00, beat.rx_byte};
            hunt      = HUNT_LEN_HI;
          end
          HUNT_LEN_HI: begin
            frame_len = {beat.rx_byte, frame_len[7:0]};
            if (frame_len >= regs.length_limit) begin
              hunt = HUNT_SYNC_A;
            end else if (frame_len == 16'd0) begin
              hunt     = HUNT_IDLE;
              res.kind = KIND_EMPTY;
              res.last = 1'b1;
              return 1'b1;
            end else begin
              bytes_in = '0;
              gap_used = '0;
              hunt     = HUNT_PAYLOAD;
            end
          end
          HUNT_PAYLOAD: begin
            bytes_in           = bytes_in + 16'd1;
            gap_used           = '0;
            res.kind           = KIND_PAYLOAD;
            res.payload_byte   = beat.rx_byte;
            res.last           = (bytes_in >= frame_len);
            res.frame_length   = frame_len;
            if (res.last) hunt = HUNT_IDLE;
            return 1'b1;
          end
          default: ;
        endcase
        return 1'b0;
      end
      default: return 1'b0;
    endcase
  endfunction

  always @(posedge clk) begin : score
    out_t got;
    out_t want;
    out_t res;
    if (rst) begin
      hunt        = HUNT_IDLE;
      frame_len   = '0;
      bytes_in    = '0;
      window_used = '0;
      gap_used    = '0;
      regs        = '{RST_CLASS, RST_ID, RST_LIMIT, RST_WINDOW, RST_GAP};
      frame_results_q.delete();
      fail_count   = 0;
      results_seen = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_CLASS:  regs.match_class  = cfg_data[7:0];
          REG_ID:     regs.match_id     = cfg_data[7:0];
          REG_LIMIT:  regs.length_limit = cfg_data;
          REG_WINDOW: regs.window_ticks = cfg_data;
          REG_GAP:    regs.gap_ticks    = cfg_data;
          default: ;
        endcase
      end
      // score the result beat before queueing anything from this edge's input beat
      if (out_valid && out_ready) begin
        got = out_data;
        results_seen++;
        if (frame_results_q.size() == 0) begin
          $error("result beat with nothing expected: kind %0d byte %0h last %0d length %0d",
                 got.kind, got.payload_byte, got.last, got.frame_length);
          fail_count++;
        end else begin
          want = frame_results_q.pop_front();
          if (got.kind !== want.kind) begin
            $error("kind: expected %0d, actual %0d", want.kind, got.kind);
            fail_count++;
          end
          if (got.payload_byte !== want.payload_byte) begin
            $error("payload_byte: expected %0h, actual %0h", want.payload_byte, got.payload_byte);
            fail_count++;
          end
          if (got.last !== want.last) begin
            $error("last: expected %0d, actual %0d", want.last, got.last);
            fail_count++;
          end
          if (got.frame_length !== want.frame_length) begin
            $error("frame_length: expected %0d, actual %0d", want.frame_length, got.frame_length);
            fail_count++;
          end
        end
      end
      if (in_valid && in_ready) begin
        if (match_beat(in_data, res)) frame_results_q.push_back(res);
      end
    end
    results_due = frame_results_q.size();
  end

endmodule

### test/tb_binary_frame_class_id_matcher_top.sv
// Testbench top for the frame class/id matcher: stimulus, flow control and verdict.
`timescale 1ns / 1ps

module tb_binary_frame_class_id_matcher_top;
  import bfcm_pkg::*;

  localparam logic [1:0] FUNC_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT = 250000;
  localparam int PHASES      = 8;
  localparam int PHASE_ITEMS = 130;

  typedef enum int {RX_OPEN, RX_CHOPPY, RX_BURSTY} rx_mode_e;

  logic                   clk;
  logic                   rst       = 1'b1;
  logic                   in_valid  = 1'b0;
  logic                   in_ready;
  in_t                    in_data   = '0;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  out_t                   out_data;
  logic                   cfg_we    = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data  = '0;

  int       fail_count;
  int       results_due;
  int       results_seen;
  int       cycles        = 0;
  int       sent          = 0;
  int       burst_left    = 0;
  int       settings_done = 0;
  int       stall_left    = 0;
  int       rx_mode_left  = 0;
  rx_mode_e rx_mode       = RX_OPEN;
  cfg_t     cur           = '{RST_CLASS, RST_ID, RST_LIMIT, RST_WINDOW, RST_GAP};

  binary_frame_class_id_matcher_top dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  bfcm_frame_checker frame_monitor (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_data      (in_data),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_data     (out_data),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .fail_count   (fail_count),
    .results_due  (results_due),
    .results_seen (results_seen)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("tb_binary_frame_class_id_matcher_top: errors");
      $finish;
    end
  end

  // receiver: open, choppy or bursty stalls, switching mode at random
  always @(negedge clk) begin
    logic rdy;
    if (rx_mode_left == 0) begin
      rx_mode      = rx_mode_e'($urandom_range(0, 2));
      rx_mode_left = $urandom_range(20, 120);
    end
    rx_mode_left--;
    if (stall_left > 0) begin
      stall_left--;
      rdy = 1'b0;
    end else begin
      case (rx_mode)
        RX_OPEN:   rdy = 1'b1;
        RX_CHOPPY: rdy = ($urandom_range(0, 2) != 0);
        default: begin
          rdy = 1'b1;
          if ($urandom_range(0, 9) == 0) begin
            stall_left = $urandom_range(2, 12);
            rdy        = 1'b0;
          end
        end
      endcase
    end
    out_ready <= rdy;
  end

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic apply_settings(input cfg_t c);
    write_reg(REG_CLASS, {8'h00, c.match_class});
    write_reg(REG_ID, {8'h00, c.match_id});
    write_reg(REG_LIMIT, c.length_limit);
    write_reg(REG_WINDOW, c.window_ticks);
    write_reg(REG_GAP, c.gap_ticks);
    cur = c;
    settings_done++;
  endtask

  // one input beat; bursts of random length, most of them preceded by a random idle gap
  task automatic send_beat(input logic [1:0] f, input logic [7:0] b);
    int idle;
    in_t beat;
    idle = 0;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      if ($urandom_range(0, 3) != 0) idle = $urandom_range(1, 7);
    end
    burst_left--;
    beat.func    = f;
    beat.rx_byte = b;
    @(negedge clk);
    if (idle > 0) begin
      in_valid <= 1'b0;
      repeat (idle) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= beat;
    do @(posedge clk); while (!in_ready);
    sent++;
  endtask

  // drop valid and wait until every expected result beat has been taken
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (results_due != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // header plus payload; a broken frame has one header byte corrupted
  task automatic send_frame(input bit broken);
    logic [7:0] hdr [6];
    int len;
    int cap;
    int pick;
    int pos;
    int i;
    if ($urandom_range(0, 9) < 8) send_beat(FUNC_START, 8'($urandom));
    if ($urandom_range(0, 3) == 0) send_beat(FUNC_BYTE, 8'($urandom));
    cap  = (cur.length_limit > 1) ? int'(cur.length_limit) - 1 : 0;
    pick = $urandom_range(0, 19);
    if (pick < 3) len = $urandom_range(int'(cur.length_limit), 65535);
    else if (cap == 0 || pick == 3) len = 0;
    else if (pick == 4) len = $urandom_range(1, (cap < 300) ? cap : 300);
    else len = $urandom_range(1, (cap < 16) ? cap : 16);
    hdr[0] = SYNC_A;
    hdr[1] = SYNC_B;
    hdr[2] = cur.match_class;
    hdr[3] = cur.match_id;
    hdr[4] = 8'(len);
    hdr[5] = 8'(len >> 8);
    if (broken) begin
      pos = $urandom_range(0, 3);
      hdr[pos] = hdr[pos] ^ 8'($urandom_range(1, 255));
    end
    for (i = 0; i < 6; i++) begin
      if ($urandom_range(0, 19) == 0) send_beat(FUNC_TICK, 8'($urandom));
      send_beat(FUNC_BYTE, hdr[i]);
    end
    if (!broken && len < cur.length_limit) begin
      for (i = 0; i < len; i++) begin
        pick = $urandom_range(0, 39);
        if (pick == 0 && cur.gap_ticks <= 64) begin
          // long enough to abandon the frame
          repeat (cur.gap_ticks) send_beat(FUNC_TICK, 8'($urandom));
        end else if (pick < 5 && cur.gap_ticks > 1) begin
          repeat ($urandom_range(1, (cur.gap_ticks > 11) ? 10 : cur.gap_ticks - 1))
            send_beat(FUNC_TICK, 8'($urandom));
        end
        send_beat(FUNC_BYTE, 8'($urandom));
      end
    end
  endtask

  initial begin
    cfg_t       c;
    int         ph;
    int         phase_end;
    int         pick;
    int         sel;
    logic [1:0] f;

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // idle: bytes, ticks and the unused code do nothing
    send_beat(FUNC_BYTE, 8'hFF);
    send_beat(FUNC_TICK, 8'h00);
    send_beat(FUNC_UNUSED, SYNC_A);
    // a repeated sync A fails sync B and is not rechecked; then an empty frame
    send_beat(FUNC_START, 8'h00);
    send_beat(FUNC_BYTE, SYNC_A);
    send_beat(FUNC_BYTE, SYNC_A);
    send_beat(FUNC_BYTE, SYNC_A);
    send_beat(FUNC_BYTE, SYNC_B);
    send_beat(FUNC_BYTE, RST_CLASS);
    send_beat(FUNC_BYTE, RST_ID);
    send_beat(FUNC_BYTE, 8'h00);
    send_beat(FUNC_BYTE, 8'h00);
    // restart mid search, length equal to limit dropped, then a two byte frame
    send_beat(FUNC_START, 8'hFF);
    send_beat(FUNC_TICK, 8'hFF);
    send_beat(FUNC_START, 8'h00);
    send_beat(FUNC_BYTE, SYNC_A);
    send_beat(FUNC_BYTE, SYNC_B);
    send_beat(FUNC_BYTE, RST_CLASS);
    send_beat(FUNC_BYTE, RST_ID);
    send_beat(FUNC_BYTE, 8'h00);
    send_beat(FUNC_BYTE, 8'h01);
    send_beat(FUNC_BYTE, SYNC_A);
    send_beat(FUNC_BYTE, SYNC_B);
    send_beat(FUNC_BYTE, RST_CLASS);
    send_beat(FUNC_BYTE, RST_ID);
    send_beat(FUNC_BYTE, 8'h02);
    send_beat(FUNC_BYTE, 8'h00);
    send_beat(FUNC_TICK, 8'h00);
    send_beat(FUNC_BYTE, 8'h00);
    send_beat(FUNC_BYTE, 8'hFF);
    settle();

    for (ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: c = '{8'h00, 8'hFF, 16'd1, 16'd1, 16'd1};
        1: c = '{8'hFF, 8'h00, 16'hFFFF, 16'hFFFF, 16'hFFFF};
        default: begin
          c.match_class  = 8'($urandom);
          c.match_id     = 8'($urandom);
          c.length_limit = ($urandom_range(0, 4) == 0) ? 16'($urandom_range(1, 65535))
                                                        : 16'($urandom_range(1, 40));
          c.window_ticks = 16'($urandom_range(2, 150));
          c.gap_ticks    = 16'($urandom_range(1, 12));
        end
      endcase
      apply_settings(c);
      phase_end = sent + PHASE_ITEMS;
      while (sent < phase_end) begin
        pick = $urandom_range(0, 99);
        if (pick < 65) begin
          send_frame(1'b0);
        end else if (pick < 80) begin
          send_frame(1'b1);
        end else if (pick < 92) begin
          repeat ($urandom_range(1, 8)) begin
            sel = $urandom_range(0, 9);
            if (sel == 0) f = FUNC_START;
            else if (sel < 6) f = FUNC_BYTE;
            else if (sel < 9) f = FUNC_TICK;
            else f = FUNC_UNUSED;
            send_beat(f, 8'($urandom));
          end
        end else if (cur.window_ticks <= 150) begin
          // run the hunting window out
          send_beat(FUNC_START, 8'($urandom));
          repeat (cur.window_ticks + $urandom_range(0, 2)) send_beat(FUNC_TICK, 8'($urandom));
        end
      end
      settle();
    end

    $display("covered %0d input beats and %0d result beats", sent, results_seen);
    $display("over reset defaults and %0d register settings, extremes included", settings_done);
    if (fail_count == 0) begin
      $display("tb_binary_frame_class_id_matcher_top: clean");
    end else begin
      $display("tb_binary_frame_class_id_matcher_top: errors");
    end
    $finish;
  end

endmodule
